>>> hw/rtl/bankers_safety_checker_unit_macros.svh
// assertion macros for the banker's safety checker
`ifndef BANKERS_SAFETY_CHECKER_UNIT_MACROS_SVH
`define BANKERS_SAFETY_CHECKER_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define BSC_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("bsc assertion failed");

// condition implies consequence in the next cycle
`define BSC_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("bsc assertion failed");

`endif

>>> hw/rtl/bsc_pkg.sv
// shared types and codes of the banker's safety checker
package bsc_pkg;

   localparam int NUM_RES = 3;

   typedef enum logic [2:0] {
      OP_LOAD_AVAIL = 3'd0,
      OP_LOAD_MAX   = 3'd1,
      OP_LOAD_HELD  = 3'd2,
      OP_REQUEST    = 3'd3,
      OP_CHECK      = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_LOADED   = 3'd0,
      ST_GRANTED  = 3'd1,
      ST_CLAIM    = 3'd2,
      ST_UNAVAIL  = 3'd3,
      ST_ROLLBACK = 3'd4,
      ST_SAFE     = 3'd5,
      ST_UNSAFE   = 3'd6
   } status_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  process;
      logic [1:0]  resource;
      logic [15:0] value;
      logic [15:0] req_a;
      logic [15:0] req_b;
      logic [15:0] req_c;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] seq_process;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      LN_IDLE       = 3'd0,
      LN_LOAD_AVAIL = 3'd1,
      LN_LOAD_MAX   = 3'd2,
      LN_LOAD_HELD  = 3'd3,
      LN_APPLY      = 3'd4,
      LN_UNDO       = 3'd5,
      LN_INIT       = 3'd6,
      LN_ADD        = 3'd7
   } lane_op_type;

   typedef struct packed {
      lane_op_type op;
      logic [15:0] value;
   } lane_cmd_type;

   typedef struct packed {
      logic claim_fail;
      logic avail_fail;
      logic fits;
   } lane_stat_type;

endpackage

>>> hw/rtl/bsc_lane.sv
// one resource type lane: counts, need test and work vector
module bsc_lane import bsc_pkg::*; #(
   parameter int NUM_PROCS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lane_cmd_type         cmd,
   input  logic [$clog2((NUM_PROCS > 1) ? NUM_PROCS : 2)-1:0] proc,
   output lane_stat_type        stat
);
   localparam int WW = 16 + $clog2(NUM_PROCS + 1);

   logic [15:0]   avail_ff;
   logic [15:0]   max_ff  [NUM_PROCS];
   logic [15:0]   held_ff [NUM_PROCS];
   logic [WW-1:0] work_ff;
   logic [15:0]   req_ff;

   logic signed [16:0] need;
   logic [15:0]        avail_less;
   logic [15:0]        held_sel;

   always_comb begin
      held_sel   = held_ff[proc];
      need       = $signed({1'b0, max_ff[proc]}) - $signed({1'b0, held_sel});
      avail_less = avail_ff - cmd.value;
      stat.claim_fail = $signed({1'b0, cmd.value}) > need;
      stat.avail_fail = cmd.value > avail_ff;
      // negative need always fits
      stat.fits = $signed({{(WW - 16){need[16]}}, need}) <= $signed({1'b0, work_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
         for (int i = 0; i < NUM_PROCS; i++) begin
            max_ff[i]  <= '0;
            held_ff[i] <= '0;
         end
      end else begin
         unique case (cmd.op)
            LN_IDLE: ;
            LN_LOAD_AVAIL: avail_ff <= cmd.value;
            LN_LOAD_MAX:   max_ff[proc] <= cmd.value;
            LN_LOAD_HELD:  held_ff[proc] <= cmd.value;
            LN_APPLY: begin
               avail_ff      <= avail_less;
               held_ff[proc] <= held_sel + cmd.value;
               req_ff        <= cmd.value;
               work_ff       <= {{(WW - 16){1'b0}}, avail_less};
            end
            LN_UNDO: begin
               avail_ff      <= avail_ff + req_ff;
               held_ff[proc] <= held_sel - req_ff;
            end
            LN_INIT: work_ff <= {{(WW - 16){1'b0}}, avail_ff};
            LN_ADD:  work_ff <= work_ff + {{(WW - 16){1'b0}}, held_sel};
            default: ;
         endcase
      end
   end
endmodule

>>> hw/rtl/bankers_safety_checker_unit.sv
// top level of the banker's safety checker: sequencer, lanes and merge
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | req_data (req_type)
//   rsp     | out | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//
// loads and refused requests are answered straight from idle, with no scan.
// a check or accepted request scans one process per cycle, pass after pass,
// until all processes fit or a pass makes no progress; an unsafe request
// rolls back before its reply; a safe check emits NUM_PROCS sequence beats.
// reset clears the lane counts to zero at once; a stalled rsp beat holds the block.
module bankers_safety_checker_unit import bsc_pkg::*; #(
   parameter int NUM_PROCS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_UNDO, S_REPLY, S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [PW-1:0]           idx_ff, idx_in;
   logic                    progress_ff, progress_in;
   logic [PW:0]             count_ff, count_in;
   logic [NUM_PROCS-1:0]    done_ff, done_in;
   logic [PW-1:0]           order_ff [NUM_PROCS];
   logic [PW-1:0]           order_in [NUM_PROCS];
   logic                    check_ff, check_in;
   logic                    safe_ff, safe_in;
   logic [PW-1:0]           proc_ff, proc_in;
   logic [PW-1:0]           emit_ff, emit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   lane_cmd_type            lane_cmd  [NUM_RES];
   lane_stat_type           lane_stat [NUM_RES];
   logic [PW-1:0]           lane_proc;

   logic                    slot_free, accept, in_range, fail, fits, all_fit;
   logic                    push, finish, new_progress;
   logic [PW:0]             new_count;
   rsp_type                 push_data;
   logic [15:0]             req_vec [NUM_RES];
   logic [PW+2:0]           proc_wide;
   logic [PW-1:0]           req_proc;
   logic [PW+2:0]           seq_wide;
   status_type              fail_st;

   for (genvar r = 0; r < NUM_RES; r++) begin : g_lane
      bsc_lane #(.NUM_PROCS(NUM_PROCS)) u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (lane_cmd[r]),
         .proc  (lane_proc),
         .stat  (lane_stat[r])
      );
   end

   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      slot_free  = !rsp_valid_ff || rsp_ready;
      accept     = req_valid && req_ready;
      in_range   = 32'(req_data.process) < NUM_PROCS;
      proc_wide  = (PW + 3)'(req_data.process);
      req_proc   = proc_wide[PW-1:0];
      req_vec[0] = req_data.req_a;
      req_vec[1] = req_data.req_b;
      req_vec[2] = req_data.req_c;

      state_in    = state_ff;
      idx_in      = idx_ff;
      progress_in = progress_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      order_in    = order_ff;
      check_in    = check_ff;
      safe_in     = safe_ff;
      proc_in     = proc_ff;
      emit_in     = emit_ff;
      push        = 1'b0;
      push_data   = '0;
      push_data.last = 1'b1;

      unique case (state_ff)
         S_IDLE:  lane_proc = req_proc;
         S_SCAN:  lane_proc = idx_ff;
         default: lane_proc = proc_ff;
      endcase

      for (int r = 0; r < NUM_RES; r++) begin
         lane_cmd[r].op    = LN_IDLE;
         lane_cmd[r].value = (state_ff == S_IDLE && req_data.op == OP_REQUEST) ?
                             req_vec[r] : req_data.value;
      end

      // merge: first failing lane in type order decides, claim before units
      fail    = 1'b0;
      fail_st = ST_CLAIM;
      all_fit = 1'b1;
      for (int r = 0; r < NUM_RES; r++) begin
         all_fit = all_fit && lane_stat[r].fits;
         if (!fail) begin
            if (lane_stat[r].claim_fail) begin
               fail    = 1'b1;
               fail_st = ST_CLAIM;
            end else if (lane_stat[r].avail_fail) begin
               fail    = 1'b1;
               fail_st = ST_UNAVAIL;
            end
         end
      end

      fits         = all_fit && !done_ff[idx_ff];
      new_count    = count_ff + (PW + 1)'(fits);
      new_progress = progress_ff || fits;
      finish       = (new_count == (PW + 1)'(NUM_PROCS)) ||
                     ((idx_ff == PW'(NUM_PROCS - 1)) && !new_progress);
      seq_wide     = (PW + 3)'(order_ff[emit_ff]);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in      = '0;
               progress_in = 1'b0;
               count_in    = '0;
               done_in     = '0;
               unique case (req_data.op)
                  OP_LOAD_AVAIL, OP_LOAD_MAX, OP_LOAD_HELD: begin
                     push = 1'b1;
                     push_data.status = ST_LOADED;
                     for (int r = 0; r < NUM_RES; r++) begin
                        if (32'(req_data.resource) == r) begin
                           if (req_data.op == OP_LOAD_AVAIL)
                              lane_cmd[r].op = LN_LOAD_AVAIL;
                           else if (in_range && req_data.op == OP_LOAD_MAX)
                              lane_cmd[r].op = LN_LOAD_MAX;
                           else if (in_range)
                              lane_cmd[r].op = LN_LOAD_HELD;
                        end
                     end
                  end
                  OP_REQUEST: begin
                     if (!in_range || fail) begin
                        push = 1'b1;
                        push_data.status = in_range ? fail_st : ST_CLAIM;
                     end else begin
                        for (int r = 0; r < NUM_RES; r++) lane_cmd[r].op = LN_APPLY;
                        check_in = 1'b0;
                        proc_in  = req_proc;
                        state_in = S_SCAN;
                     end
                  end
                  OP_CHECK: begin
                     for (int r = 0; r < NUM_RES; r++) lane_cmd[r].op = LN_INIT;
                     check_in = 1'b1;
                     state_in = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (fits) begin
               for (int r = 0; r < NUM_RES; r++) lane_cmd[r].op = LN_ADD;
               done_in[idx_ff]               = 1'b1;
               order_in[count_ff[PW-1:0]]    = idx_ff;
            end
            count_in = new_count;
            if (finish) begin
               safe_in = new_count == (PW + 1)'(NUM_PROCS);
               emit_in = '0;
               if (check_in && safe_in)
                  state_in = S_EMIT;
               else if (!check_ff && !safe_in)
                  state_in = S_UNDO;
               else
                  state_in = S_REPLY;
            end else if (idx_ff == PW'(NUM_PROCS - 1)) begin
               idx_in      = '0;
               progress_in = 1'b0;
            end else begin
               idx_in      = idx_ff + 1'b1;
               progress_in = new_progress;
            end
         end
         S_UNDO: begin
            for (int r = 0; r < NUM_RES; r++) lane_cmd[r].op = LN_UNDO;
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (slot_free) begin
               push = 1'b1;
               if (check_ff)
                  push_data.status = ST_UNSAFE;
               else
                  push_data.status = safe_ff ? ST_GRANTED : ST_ROLLBACK;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               push = 1'b1;
               push_data.status      = ST_SAFE;
               push_data.seq_process = seq_wide[2:0];
               push_data.last        = emit_ff == PW'(NUM_PROCS - 1);
               if (push_data.last)
                  state_in = S_IDLE;
               else
                  emit_in = emit_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = push_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      progress_ff <= progress_in;
      count_ff    <= count_in;
      done_ff     <= done_in;
      order_ff    <= order_in;
      check_ff    <= check_in;
      safe_ff     <= safe_in;
      proc_ff     <= proc_in;
      emit_ff     <= emit_in;
      rsp_ff      <= rsp_in;
   end
endmodule

>>> hw/rtl/bsc_checker.sv
// port-level assertions of the banker's safety checker and their bind
`include "bankers_safety_checker_unit_macros.svh"

module bsc_checker import bsc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `BSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `BSC_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_data.status != 3'd7)
   `BSC_ASSERT_NOW(a_single_last, clock, reset, rsp_valid && rsp_data.status != ST_SAFE, rsp_data.last)
   `BSC_ASSERT_NOW(a_seq_zero, clock, reset, rsp_valid && rsp_data.status != ST_SAFE, rsp_data.seq_process == 3'd0)
endmodule

bind bankers_safety_checker_unit bsc_checker u_bsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
